/* src/hlps_pkg.sv */
// ----------------------------------------------------------------------------
// hlps_pkg
// shared widths, fixed-point constants and series tables for the phase and
// coefficient shift block
// ----------------------------------------------------------------------------
package hlps_pkg;

  localparam int COEF_WIDTH  = 24;
  localparam int ANGLE_BITS  = 16;
  localparam int SHIFT_W     = 16;
  localparam int PHASE_IN_W  = 17;
  localparam int PHASE_OUT_W = 15;
  localparam int PHASE_FULL  = 23040;

  // reduced angle inside one quadrant
  localparam int RED_W = ANGLE_BITS - 2;

  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  localparam int COS_STEPS = 5;
  localparam int SIN_STEPS = 4;
  localparam int STEP_LAT  = 3;
  // fold, angle scale, square, series steps, unfold
  localparam int SC_LAT    = 3 + COS_STEPS * STEP_LAT + 1;

  // series divisors with truncating reciprocals floor(2^sh / div)
  localparam logic [6:0]  COS_DIV [COS_STEPS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
  localparam logic [30:0] COS_RCP [COS_STEPS] = '{31'd1527099483, 31'd1227133513,
                                                  31'd1145324612, 31'd1431655765,
                                                  31'd1073741824};
  localparam int          COS_SH  [COS_STEPS] = '{37, 36, 35, 34, 31};

  localparam logic [6:0]  SIN_DIV [SIN_STEPS] = '{7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [30:0] SIN_RCP [SIN_STEPS] = '{31'd1908874353, 31'd1636178017,
                                                  31'd1717986918, 31'd1431655765};
  localparam int          SIN_SH  [SIN_STEPS] = '{37, 36, 35, 33};

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic signed [31:0]           trig_t;
  typedef logic [ANGLE_BITS-1:0]        angle_t;

endpackage

/* src/hlps_in_if.sv */
// ----------------------------------------------------------------------------
// hlps_in_if
// input channel: one reflection with its phase shift
// ----------------------------------------------------------------------------
interface hlps_in_if;
  import hlps_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [PHASE_IN_W-1:0]  phase_in;
  coef_t                         hla_in;
  coef_t                         hlb_in;
  coef_t                         hlc_in;
  coef_t                         hld_in;
  logic [SHIFT_W-1:0]            shift_turns;
  logic                          negate;

  modport source (
    output valid, phase_in, hla_in, hlb_in, hlc_in, hld_in, shift_turns, negate,
    input  ready
  );
  modport sink (
    input  valid, phase_in, hla_in, hlb_in, hlc_in, hld_in, shift_turns, negate,
    output ready
  );
endinterface

/* src/hlps_out_if.sv */
// ----------------------------------------------------------------------------
// hlps_out_if
// output channel: shifted phase and rotated coefficients
// ----------------------------------------------------------------------------
interface hlps_out_if;
  import hlps_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [PHASE_OUT_W-1:0]   phase_out;
  coef_t                    hla_out;
  coef_t                    hlb_out;
  coef_t                    hlc_out;
  coef_t                    hld_out;
  logic                     saturated;

  modport source (
    output valid, phase_out, hla_out, hlb_out, hlc_out, hld_out, saturated,
    input  ready
  );
  modport sink (
    input  valid, phase_out, hla_out, hlb_out, hlc_out, hld_out, saturated,
    output ready
  );
endinterface

/* src/hlps_sincos.sv */
// ----------------------------------------------------------------------------
// hlps_sincos
// pipelined Q30 sine and cosine: octant fold, truncated Taylor series in
// Horner form, one divide-by-constant step every three stages
// ----------------------------------------------------------------------------
module hlps_sincos (
  input  logic            clk_i,
  input  logic            en_i,
  input  hlps_pkg::angle_t angle_i,
  output hlps_pkg::trig_t sin_o,
  output hlps_pkg::trig_t cos_o
);
  import hlps_pkg::*;

  localparam int MD_LEN = 1 + COS_STEPS * STEP_LAT;
  localparam logic [RED_W:0] QTURN = (RED_W+1)'(1) << RED_W;
  localparam logic [RED_W:0] OCT   = (RED_W+1)'(1) << (RED_W - 1);

  typedef struct packed {
    logic [29:0] x2;
    logic [29:0] x;
    logic [1:0]  quad;
    logic        fold;
  } meta_t;

  logic [RED_W-1:0] r_raw;
  logic             fold_d;
  logic [RED_W-1:0] red_a_q;
  logic [1:0]       quad_a_q, quad_b_q;
  logic             fold_a_q, fold_b_q;
  logic [RED_W+31:0] xp;
  logic [29:0]      x_b_q;
  logic [59:0]      xx;
  meta_t            md_q [MD_LEN];

  logic [30:0] cp_q [COS_STEPS];
  logic [30:0] sp_q [SIN_STEPS];
  logic [60:0] sn_full;
  logic [30:0] sn_q, sn_d1_q, sn_d2_q;
  logic [30:0] su, cu;
  trig_t       sv, cv;
  trig_t       sin_q, cos_q;

  assign r_raw  = angle_i[RED_W-1:0];
  assign fold_d = {1'b0, r_raw} > OCT;

  // stage a: fold into the first octant
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad_a_q <= angle_i[ANGLE_BITS-1 -: 2];
      fold_a_q <= fold_d;
      red_a_q  <= fold_d ? RED_W'(QTURN - {1'b0, r_raw}) : r_raw;
    end
  end

  // stage b: angle in Q30 radians
  assign xp = (RED_W+32)'(red_a_q) * (RED_W+32)'(PI_Q30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_b_q    <= 30'(xp >> (ANGLE_BITS - 1));
      quad_b_q <= quad_a_q;
      fold_b_q <= fold_a_q;
    end
  end

  // stage c: square, then a delay line that feeds every series step
  assign xx = 60'(x_b_q) * 60'(x_b_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      md_q[0] <= '{x2: xx[59:30], x: x_b_q, quad: quad_b_q, fold: fold_b_q};
      for (int j = 1; j < MD_LEN; j++) begin
        md_q[j] <= md_q[j-1];
      end
    end
  end

  // cosine series, 1 - x2/90 ... down to 1 - x2/2
  for (genvar i = 0; i < COS_STEPS; i++) begin : g_cos
    logic [60:0] prod_q;
    logic [29:0] h_q;
    logic [60:0] est_q;
    logic [30:0] p_in;
    logic [30:0] q_est, q_fix;
    logic [37:0] qd, rem;

    assign p_in  = (i == 0) ? ONE_Q30 : cp_q[(i > 0) ? i - 1 : 0];
    assign q_est = 31'(est_q >> COS_SH[i]);
    assign qd    = 38'(q_est) * 38'(COS_DIV[i]);
    assign rem   = 38'(h_q) - qd;
    assign q_fix = q_est + 31'(rem >= 38'(COS_DIV[i]));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q <= 61'(md_q[i*STEP_LAT].x2) * 61'(p_in);
        h_q    <= prod_q[59:30];
        est_q  <= 61'(prod_q[59:30]) * 61'(COS_RCP[i]);
        cp_q[i] <= ONE_Q30 - q_fix;
      end
    end
  end

  // sine series, 1 - x2/72 ... down to 1 - x2/6, then times x
  for (genvar i = 0; i < SIN_STEPS; i++) begin : g_sin
    logic [60:0] prod_q;
    logic [29:0] h_q;
    logic [60:0] est_q;
    logic [30:0] p_in;
    logic [30:0] q_est, q_fix;
    logic [37:0] qd, rem;

    assign p_in  = (i == 0) ? ONE_Q30 : sp_q[(i > 0) ? i - 1 : 0];
    assign q_est = 31'(est_q >> SIN_SH[i]);
    assign qd    = 38'(q_est) * 38'(SIN_DIV[i]);
    assign rem   = 38'(h_q) - qd;
    assign q_fix = q_est + 31'(rem >= 38'(SIN_DIV[i]));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q <= 61'(md_q[i*STEP_LAT].x2) * 61'(p_in);
        h_q    <= prod_q[59:30];
        est_q  <= 61'(prod_q[59:30]) * 61'(SIN_RCP[i]);
        sp_q[i] <= ONE_Q30 - q_fix;
      end
    end
  end

  assign sn_full = 61'(md_q[SIN_STEPS*STEP_LAT].x) * 61'(sp_q[SIN_STEPS-1]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sn_q    <= sn_full[60:30];
      sn_d1_q <= sn_q;
      sn_d2_q <= sn_d1_q;
    end
  end

  // unfold by octant and quadrant
  assign su = md_q[MD_LEN-1].fold ? cp_q[COS_STEPS-1] : sn_d2_q;
  assign cu = md_q[MD_LEN-1].fold ? sn_d2_q : cp_q[COS_STEPS-1];
  assign sv = trig_t'({1'b0, su});
  assign cv = trig_t'({1'b0, cu});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (quad_e'(md_q[MD_LEN-1].quad))
        QUAD_0: begin
          sin_q <= sv;
          cos_q <= cv;
        end
        QUAD_1: begin
          sin_q <= cv;
          cos_q <= -sv;
        end
        QUAD_2: begin
          sin_q <= -sv;
          cos_q <= -cv;
        end
        default: begin
          sin_q <= -cv;
          cos_q <= sv;
        end
      endcase
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

/* src/hlps_rot.sv */
// ----------------------------------------------------------------------------
// hlps_rot
// rotates one coefficient pair by a Q30 sine/cosine, rounds, optionally
// negates the second output and saturates
// ----------------------------------------------------------------------------
module hlps_rot (
  input  logic            clk_i,
  input  logic            en_i,
  input  hlps_pkg::coef_t a_i,
  input  hlps_pkg::coef_t b_i,
  input  hlps_pkg::trig_t sin_i,
  input  hlps_pkg::trig_t cos_i,
  input  logic            neg_i,
  output hlps_pkg::coef_t x_o,
  output hlps_pkg::coef_t y_o,
  output logic            sat_o
);
  import hlps_pkg::*;

  localparam int PW = COEF_WIDTH + 32;
  localparam int RW = COEF_WIDTH + 4;
  localparam logic signed [PW:0]   HALF = (PW+1)'(64'sd1 <<< 29);
  localparam logic signed [RW-1:0] HI   = RW'((64'sd1 <<< (COEF_WIDTH - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] LO   = -HI - RW'(1);

  logic signed [PW-1:0] ac_q, bs_q, as_q, bc_q;
  logic                 neg_q;
  logic signed [PW:0]   sx, sy;
  logic signed [RW-1:0] xr, yr;
  logic signed [RW-1:0] xr_q, yr_q;
  logic                 x_hi, x_lo, y_hi, y_lo;
  coef_t                x_q, y_q;
  logic                 sat_q;

  // products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q  <= PW'(a_i) * PW'(cos_i);
      bs_q  <= PW'(b_i) * PW'(sin_i);
      as_q  <= PW'(a_i) * PW'(sin_i);
      bc_q  <= PW'(b_i) * PW'(cos_i);
      neg_q <= neg_i;
    end
  end

  // sums, round half up out of Q30
  assign sx = (PW+1)'(ac_q) - (PW+1)'(bs_q) + HALF;
  assign sy = (PW+1)'(as_q) + (PW+1)'(bc_q) + HALF;
  assign xr = RW'(sx >>> 30);
  assign yr = neg_q ? -RW'(sy >>> 30) : RW'(sy >>> 30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xr_q <= xr;
      yr_q <= yr;
    end
  end

  // clip
  assign x_hi = xr_q > HI;
  assign x_lo = xr_q < LO;
  assign y_hi = yr_q > HI;
  assign y_lo = yr_q < LO;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_hi ? coef_t'(HI) : (x_lo ? coef_t'(LO) : coef_t'(xr_q));
      y_q   <= y_hi ? coef_t'(HI) : (y_lo ? coef_t'(LO) : coef_t'(yr_q));
      sat_q <= x_hi | x_lo | y_hi | y_lo;
    end
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign sat_o = sat_q;

endmodule

/* src/phase_and_hl_coefficient_shift.sv */
// ----------------------------------------------------------------------------
// phase_and_hl_coefficient_shift
// symmetry phase shift of one reflection: phase and Hendrickson-Lattman
// coefficients, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   in_i carries one reflection per transfer: phase (1/64 degree), the four
//   coefficients, the shift as a fraction of a turn and the negate flag.
//   out_o returns one result per input transfer, in order: the wrapped phase,
//   the rotated coefficients and a flag that is set when any was clipped.
//   throughput is one transfer per cycle while out_o does not stall; the
//   sine/cosine series pipeline (19 stages, three per divide-by-constant
//   step) plus three rotate stages sets the depth, and each result then
//   passes through the output register before it shows on out_o.
//   the whole pipeline advances together; a skid register behind the output
//   register catches the one result that arrives while out_o is stalled, and
//   in_i.ready drops only while that skid register is full.
//   reset clears the valid bits and the output and skid flags; the block takes
//   input in the first cycle after reset.
// ----------------------------------------------------------------------------
module phase_and_hl_coefficient_shift (
  input  logic     clk_i,
  input  logic     rst_ni,
  hlps_in_if.sink  in_i,
  hlps_out_if.source out_o
);
  import hlps_pkg::*;

  localparam int TOT_LAT = SC_LAT + 3;
  localparam logic [17:0] F1 = 18'(PHASE_FULL);
  localparam logic [17:0] F2 = 18'(2 * PHASE_FULL);
  localparam logic [17:0] F4 = 18'(4 * PHASE_FULL);
  localparam logic [31:0] ROUND_HALF = 32'(1) << (ANGLE_BITS - 1);

  typedef struct packed {
    logic signed [PHASE_IN_W-1:0] phase;
    coef_t                        a;
    coef_t                        b;
    coef_t                        c;
    coef_t                        d;
    angle_t                       ang;
    logic                         neg;
  } item_t;

  typedef struct packed {
    logic [PHASE_OUT_W-1:0] phase;
    coef_t                  a;
    coef_t                  b;
    coef_t                  c;
    coef_t                  d;
    logic                   sat;
  } res_t;

  logic   en;
  logic   vld_q [TOT_LAT];
  item_t  dl_q  [SC_LAT];
  item_t  cur;
  angle_t ang_in, ang2_in;
  trig_t  s1, c1, s2, c2;
  coef_t  ra, rb, rc, rd;
  logic   sat1, sat2;

  // phase path
  logic [31:0]                  su_full;
  logic [14:0]                  su_q;
  logic signed [PHASE_IN_W-1:0] ph1_q;
  logic                         neg1_q;
  logic signed [18:0]           total;
  logic [17:0]                  wrap4;
  logic [17:0]                  ph2_q, ph2b;
  logic [PHASE_OUT_W-1:0]       ph3_q;

  // output register and skid
  logic out_v_q, skid_v_q;
  res_t out_q, skid_q, push_data;
  logic push;

  assign en         = !skid_v_q;
  assign in_i.ready = en;

  // valid bits travel with the items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < TOT_LAT; j++) begin
        vld_q[j] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_i.valid;
      for (int j = 1; j < TOT_LAT; j++) begin
        vld_q[j] <= vld_q[j-1];
      end
    end
  end

  // payload delay line while sine and cosine are formed
  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_q[0] <= '{phase: in_i.phase_in, a: in_i.hla_in, b: in_i.hlb_in,
                   c: in_i.hlc_in, d: in_i.hld_in,
                   ang: in_i.shift_turns[ANGLE_BITS-1:0], neg: in_i.negate};
      for (int j = 1; j < SC_LAT; j++) begin
        dl_q[j] <= dl_q[j-1];
      end
    end
  end

  assign cur     = dl_q[SC_LAT-1];
  assign ang_in  = in_i.shift_turns[ANGLE_BITS-1:0];
  assign ang2_in = {ang_in[ANGLE_BITS-2:0], 1'b0};

  hlps_sincos u_sc1 (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (ang_in),
    .sin_o   (s1),
    .cos_o   (c1)
  );

  // double angle
  hlps_sincos u_sc2 (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (ang2_in),
    .sin_o   (s2),
    .cos_o   (c2)
  );

  hlps_rot u_rot_ab (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (cur.a),
    .b_i   (cur.b),
    .sin_i (s1),
    .cos_i (c1),
    .neg_i (cur.neg),
    .x_o   (ra),
    .y_o   (rb),
    .sat_o (sat1)
  );

  hlps_rot u_rot_cd (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (cur.c),
    .b_i   (cur.d),
    .sin_i (s2),
    .cos_i (c2),
    .neg_i (cur.neg),
    .x_o   (rc),
    .y_o   (rd),
    .sat_o (sat2)
  );

  // phase: shift in phase units, rounded half up
  assign su_full = 32'(cur.ang) * 32'(PHASE_FULL) + ROUND_HALF;

  always_ff @(posedge clk_i) begin
    if (en) begin
      su_q   <= 15'(su_full >> ANGLE_BITS);
      ph1_q  <= cur.phase;
      neg1_q <= cur.neg;
    end
  end

  // add, negate, lift by four turns so the value is never negative
  assign total = 19'(ph1_q) + 19'($signed({1'b0, su_q}));
  assign wrap4 = neg1_q ? 18'(19'(F4) - total) : 18'(total + 19'(F4));

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph2_q <= (wrap4 >= F4) ? wrap4 - F4 : wrap4;
    end
  end

  assign ph2b = (ph2_q >= F2) ? ph2_q - F2 : ph2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph3_q <= PHASE_OUT_W'((ph2b >= F1) ? ph2b - F1 : ph2b);
    end
  end

  // output register with skid
  assign push      = vld_q[TOT_LAT-1] && en;
  assign push_data = '{phase: ph3_q, a: ra, b: rb, c: rc, d: rd, sat: sat1 | sat2};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_o.ready) begin
      out_v_q  <= skid_v_q || push;
      skid_v_q <= 1'b0;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_o.ready) begin
      out_q <= skid_v_q ? skid_q : push_data;
    end else if (push) begin
      skid_q <= push_data;
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.phase_out = out_q.phase;
  assign out_o.hla_out   = out_q.a;
  assign out_o.hlb_out   = out_q.b;
  assign out_o.hlc_out   = out_q.c;
  assign out_o.hld_out   = out_q.d;
  assign out_o.saturated = out_q.sat;

endmodule
